// ===== src/nbc_pkg.sv =====
// Shared types and codes for the IPv6 neighbor cache.
`default_nettype none

package nbc_pkg;

  localparam logic [1:0] MODE_LEARN  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_EXPIRE = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [47:0] mac_in;
    logic [63:0] expiry_time;
    logic [63:0] current_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac_out;
    logic [4:0]  expired_count;
  } rsp_t;

  // One table entry as it sits in the entry memory.
  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [47:0] mac;
    logic [63:0] expiry;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Compare result for one entry against the current request.
  typedef struct packed {
    logic addr_hit;
    logic live;
    logic stale;
  } match_t;

endpackage

`default_nettype wire

// ===== src/ipv6_neighbor_cache.sv =====
// Top level of the IPv6 neighbor cache: request sequencer, valid marks and entry memory.
//
// Usage: a request beat (learn, lookup or expire) enters on in_data_i when in_valid_i is
// high and in_stall_o is low. Exactly one response beat leaves on out_data_o per request,
// taken when out_valid_o is high and out_stall_i is low.
// Each learn, lookup or expire request scans the whole table through the entry memory, one
// entry per cycle. The memory has one read port with registered read data. A request
// scans, then writes back for a learn, then forms the response; the unused mode skips
// the scan. One request is in flight at a time; the next is accepted in the cycle after
// the response is loaded into the output register.
// The output register holds a finished response while the receiver stalls; a following
// request may be scanned meanwhile and then waits until that register frees up.
// Reset clears all valid marks at once (they live in flip-flops) and empties the output
// register. Entry memory contents are not cleared: an entry is only used where it is valid.
`default_nettype none

module ipv6_neighbor_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire nbc_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output nbc_pkg::rsp_t      out_data_o
);
  import nbc_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]      state_q, state_d;
  req_t            req_q;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] found_idx_q, found_idx_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [47:0]     mac_q, mac_d;
  logic [4:0]      count_q, count_d;
  logic            valid_q [ENTRIES];
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic            in_take;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [IdxW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t          rd_entry;
  entry_t          wr_entry;
  match_t          hit;
  logic            set_valid;
  logic            clr_valid;

  // Entry memory: address, MAC and expiry of every slot.
  nbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (wr_entry),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  nbc_match u_match (
    .entry_i   (rd_entry),
    .valid_i   (valid_q[cmp_idx_q]),
    .addr_hi_i (req_q.address_high),
    .addr_lo_i (req_q.address_low),
    .now_i     (req_q.current_time),
    .match_o   (hit)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ram_raddr = rd_cnt_q[IdxW-1:0];

  assign wr_entry.addr_hi = req_q.address_high;
  assign wr_entry.addr_lo = req_q.address_low;
  assign wr_entry.mac     = req_q.mac_in;
  assign wr_entry.expiry  = req_q.expiry_time;

  // Learn writes back to the matching slot, or else to the first free one. The scan never
  // writes, so no read can overlap a write to the same entry.
  assign ram_we    = (state_q == ST_WRITE) && (found_q || free_q);
  assign ram_waddr = found_q ? found_idx_q : free_idx_q;
  assign set_valid = ram_we;
  assign clr_valid = (state_q == ST_SCAN) && cmp_vld_q && (req_q.mode == MODE_EXPIRE) &&
                     hit.stale;

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    mac_d       = mac_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          rd_cnt_d = '0;
          found_d  = 1'b0;
          free_d   = 1'b0;
          mac_d    = '0;
          count_d  = '0;
          // The unused mode does nothing and answers at once.
          if (in_data_i.mode == MODE_LEARN || in_data_i.mode == MODE_LOOKUP ||
              in_data_i.mode == MODE_EXPIRE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; its data is checked in the following cycle.
        if (rd_cnt_q < CntW'(ENTRIES)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[IdxW-1:0];
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (req_q.mode == MODE_LEARN) begin
            if (hit.addr_hit && !found_q) begin
              found_d     = 1'b1;
              found_idx_d = cmp_idx_q;
            end
            if (!valid_q[cmp_idx_q] && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = cmp_idx_q;
            end
          end else if (req_q.mode == MODE_LOOKUP) begin
            if (hit.live && !found_q) begin
              found_d = 1'b1;
              mac_d   = rd_entry.mac;
            end
          end else if (clr_valid && count_q != COUNT_MAX) begin
            count_d = count_q + 5'd1;
          end
          if (cmp_idx_q == LastIdx) begin
            state_d = (req_q.mode == MODE_LEARN) ? ST_WRITE : ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (req_q.mode == MODE_LEARN) begin
            out_d.status = (found_q || free_q) ? STATUS_OK : STATUS_FULL;
          end else if (req_q.mode == MODE_LOOKUP) begin
            out_d.status  = found_q ? STATUS_OK : STATUS_MISS;
            out_d.mac_out = mac_q;
          end else if (req_q.mode == MODE_EXPIRE) begin
            out_d.expired_count = count_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (set_valid) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (clr_valid) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_data_i;
    end
    rd_cnt_q    <= rd_cnt_d;
    cmp_idx_q   <= cmp_idx_d;
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    mac_q       <= mac_d;
    count_q     <= count_d;
    out_q       <= out_d;
  end

  // A compare is only ever pending while a scan is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> state_q == ST_SCAN)
    else $error("compare pending outside of a scan");

  // Write-back only happens for learn requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> req_q.mode == MODE_LEARN)
    else $error("write-back for a request that is not a learn");

  // A new response is only loaded from the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |-> $past(state_q == ST_DONE))
    else $error("response loaded outside the response state");

  // A nonzero MAC or count is only reported with success status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.mac_out != '0 || out_q.expired_count != '0))
      |-> out_q.status == STATUS_OK)
    else $error("payload reported together with a failure status");

endmodule

`default_nettype wire

// ===== src/nbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== src/nbc_match.sv =====
// Compares one table entry against the address and time of a request.
`default_nettype none

module nbc_match (
  input  wire nbc_pkg::entry_t entry_i,
  input  wire logic            valid_i,
  input  wire logic [63:0]     addr_hi_i,
  input  wire logic [63:0]     addr_lo_i,
  input  wire logic [63:0]     now_i,
  output nbc_pkg::match_t      match_o
);
  import nbc_pkg::*;

  logic addr_eq;
  logic after_now;

  assign addr_eq   = (entry_i.addr_hi == addr_hi_i) && (entry_i.addr_lo == addr_lo_i);
  assign after_now = entry_i.expiry > now_i;

  assign match_o.addr_hit = valid_i && addr_eq;
  assign match_o.live     = valid_i && addr_eq && after_now;
  assign match_o.stale    = valid_i && !after_now;

endmodule

`default_nettype wire
